>>> rtl/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// cpcr_pkg: shared types, constants and helpers
// Payload structs, pipeline sideband and the fixed-point rounding helpers
// used by the circle pair collision response pipeline.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  // Pipeline geometry
  localparam int RAD_W      = 34;  // squared distance width when overlapping
  localparam int ROOT_W     = 17;  // floor square root width
  localparam int SQ_STAGES  = 17;  // one root bit per stage
  localparam int DIV_STAGES = 17;  // one quotient bit per stage
  localparam int NORM_W     = 18;  // signed Q1.16 normal component
  localparam int NORM_BITS  = 16;

  // Friction gain register
  localparam logic [16:0] GAIN_ONE   = 17'd65536;
  localparam logic [16:0] GAIN_RESET = 17'd58982;

  // Output saturation bounds
  localparam logic signed [63:0] SAT_MAX = 64'sd8388607;
  localparam logic signed [63:0] SAT_MIN = -64'sd8388608;

  typedef struct packed {
    logic signed [23:0] first_pos_x;
    logic signed [23:0] first_pos_y;
    logic signed [23:0] first_vel_x;
    logic signed [23:0] first_vel_y;
    logic        [15:0] first_radius;
    logic signed [23:0] second_pos_x;
    logic signed [23:0] second_pos_y;
    logic signed [23:0] second_vel_x;
    logic signed [23:0] second_vel_y;
    logic        [15:0] second_radius;
  } in_t;

  typedef struct packed {
    logic signed [23:0] new_first_pos_x;
    logic signed [23:0] new_first_pos_y;
    logic signed [23:0] new_first_vel_x;
    logic signed [23:0] new_first_vel_y;
    logic signed [23:0] new_second_pos_x;
    logic signed [23:0] new_second_pos_y;
    logic signed [23:0] new_second_vel_x;
    logic signed [23:0] new_second_vel_y;
    logic               collided;
  } out_t;

  // Sideband that rides along the root and divide stages
  typedef struct packed {
    in_t         pair;
    logic        hit;
    logic [16:0] rs;
    logic [16:0] dx_mag;
    logic        dx_neg;
    logic [16:0] dy_mag;
    logic        dy_neg;
  } side_t;

  // Divide by 2^sh, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int sh);
    logic signed [63:0] half;
    logic signed [63:0] bias;
    half = 64'sd1 <<< (sh - 1);
    bias = v[63] ? (half - 64'sd1) : half;
    return (v + bias) >>> sh;
  endfunction

  // Clamp to the 24 bit signed range
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] res;
    if (v > SAT_MAX) begin
      res = SAT_MAX[23:0];
    end else if (v < SAT_MIN) begin
      res = SAT_MIN[23:0];
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/cpcr_sqrt.sv
// ----------------------------------------------------------------------------
// cpcr_sqrt: pipelined floor square root
// Digit-by-digit square root of a 34 bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module cpcr_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [cpcr_pkg::RAD_W-1:0]    in_rad,
  input  cpcr_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [cpcr_pkg::ROOT_W-1:0]   out_root,
  output cpcr_pkg::side_t               out_side
);

  localparam int N = cpcr_pkg::SQ_STAGES;

  logic                          v_r    [N];
  logic [cpcr_pkg::RAD_W-1:0]    rad_r  [N];
  logic [20:0]                   rem_r  [N];
  logic [cpcr_pkg::ROOT_W-1:0]   root_r [N];
  cpcr_pkg::side_t               side_r [N];

  logic [cpcr_pkg::RAD_W-1:0]    src_rad  [N];
  logic [20:0]                   src_rem  [N];
  logic [cpcr_pkg::ROOT_W-1:0]   src_root [N];
  cpcr_pkg::side_t               src_side [N];
  logic [20:0]                   rem_sh   [N];
  logic [20:0]                   trial    [N];
  logic [20:0]                   rem_nxt  [N];
  logic [cpcr_pkg::ROOT_W-1:0]   root_nxt [N];

  // Stage sources: entry for the first stage, previous stage otherwise
  always_comb begin
    src_rad[0]  = in_rad;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_side[0] = in_side;
    for (int i = 1; i < N; i++) begin
      src_rad[i]  = rad_r[i-1];
      src_rem[i]  = rem_r[i-1];
      src_root[i] = root_r[i-1];
      src_side[i] = side_r[i-1];
    end
  end

  // One trial subtract per stage, next bit pair from the top down
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rem_sh[i] = {src_rem[i][18:0], src_rad[i][cpcr_pkg::RAD_W-1-2*i -: 2]};
      trial[i]  = {2'b00, src_root[i], 2'b01};
      if (rem_sh[i] >= trial[i]) begin
        rem_nxt[i]  = rem_sh[i] - trial[i];
        root_nxt[i] = {src_root[i][cpcr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = rem_sh[i];
        root_nxt[i] = {src_root[i][cpcr_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rad_r[i]  <= src_rad[i];
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        side_r[i] <= src_side[i];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

>>> rtl/cpcr_div.sv
// ----------------------------------------------------------------------------
// cpcr_div: pipelined normal divider
// Two restoring dividers form |d| * 2^16 / h for x and y, one quotient bit
// per stage, then apply signs to give the unit normal and its tangent.
// ----------------------------------------------------------------------------
module cpcr_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [cpcr_pkg::ROOT_W-1:0]         in_root,
  input  cpcr_pkg::side_t                     in_side,
  output logic                                out_valid,
  output cpcr_pkg::side_t                     out_side,
  output logic signed [cpcr_pkg::NORM_W-1:0]  out_nx,
  output logic signed [cpcr_pkg::NORM_W-1:0]  out_ny,
  output logic signed [cpcr_pkg::NORM_W-1:0]  out_tx,
  output logic [16:0]                         out_ov
);

  localparam int N = cpcr_pkg::DIV_STAGES;

  logic              v_r    [N];
  logic [16:0]       h_r    [N];
  logic [16:0]       ov_r   [N];
  logic [16:0]       remx_r [N];
  logic [16:0]       remy_r [N];
  logic [16:0]       qx_r   [N];
  logic [16:0]       qy_r   [N];
  cpcr_pkg::side_t   side_r [N];

  logic [16:0]       src_h    [N];
  logic [16:0]       src_ov   [N];
  logic [16:0]       src_remx [N];
  logic [16:0]       src_remy [N];
  logic [16:0]       src_qx   [N];
  logic [16:0]       src_qy   [N];
  cpcr_pkg::side_t   src_side [N];
  logic [17:0]       shx      [N];
  logic [17:0]       shy      [N];
  logic [17:0]       difx     [N];
  logic [17:0]       dify     [N];
  logic [16:0]       remx_nxt [N];
  logic [16:0]       remy_nxt [N];
  logic [16:0]       qx_nxt   [N];
  logic [16:0]       qy_nxt   [N];

  logic [17:0]       ov_full;
  logic [17:0]       magx;
  logic [17:0]       magy;
  logic              hzero;

  // Overlap depth at entry; only meaningful on a hit
  assign ov_full = {1'b0, in_side.rs} - {1'b0, in_root};

  // Stage sources; the upper quotient bits are known zero since |d| <= h
  always_comb begin
    src_h[0]    = in_root;
    src_ov[0]   = ov_full[16:0];
    src_remx[0] = {1'b0, in_side.dx_mag[16:1]};
    src_remy[0] = {1'b0, in_side.dy_mag[16:1]};
    src_qx[0]   = '0;
    src_qy[0]   = '0;
    src_side[0] = in_side;
    for (int i = 1; i < N; i++) begin
      src_h[i]    = h_r[i-1];
      src_ov[i]   = ov_r[i-1];
      src_remx[i] = remx_r[i-1];
      src_remy[i] = remy_r[i-1];
      src_qx[i]   = qx_r[i-1];
      src_qy[i]   = qy_r[i-1];
      src_side[i] = side_r[i-1];
    end
  end

  // Compare and subtract, one quotient bit each
  always_comb begin
    for (int i = 0; i < N; i++) begin
      shx[i]  = {src_remx[i], (i == 0) ? src_side[i].dx_mag[0] : 1'b0};
      shy[i]  = {src_remy[i], (i == 0) ? src_side[i].dy_mag[0] : 1'b0};
      difx[i] = shx[i] - {1'b0, src_h[i]};
      dify[i] = shy[i] - {1'b0, src_h[i]};
      if (shx[i] >= {1'b0, src_h[i]}) begin
        remx_nxt[i] = difx[i][16:0];
        qx_nxt[i]   = {src_qx[i][15:0], 1'b1};
      end else begin
        remx_nxt[i] = shx[i][16:0];
        qx_nxt[i]   = {src_qx[i][15:0], 1'b0};
      end
      if (shy[i] >= {1'b0, src_h[i]}) begin
        remy_nxt[i] = dify[i][16:0];
        qy_nxt[i]   = {src_qy[i][15:0], 1'b1};
      end else begin
        remy_nxt[i] = shy[i][16:0];
        qy_nxt[i]   = {src_qy[i][15:0], 1'b0};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) v_r[i] <= v_r[i-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        h_r[i]    <= src_h[i];
        ov_r[i]   <= src_ov[i];
        remx_r[i] <= remx_nxt[i];
        remy_r[i] <= remy_nxt[i];
        qx_r[i]   <= qx_nxt[i];
        qy_r[i]   <= qy_nxt[i];
        side_r[i] <= src_side[i];
      end
    end
  end

  // Signed normal; coincident centres give a zero normal
  assign hzero = (h_r[N-1] == '0);
  assign magx  = {1'b0, qx_r[N-1]};
  assign magy  = {1'b0, qy_r[N-1]};

  always_comb begin
    if (hzero) begin
      out_nx = '0;
      out_ny = '0;
      out_tx = '0;
    end else begin
      out_nx = side_r[N-1].dx_neg ? -magx : magx;
      out_ny = side_r[N-1].dy_neg ? -magy : magy;
      out_tx = side_r[N-1].dy_neg ? magy : -magy;
    end
  end

  assign out_valid = v_r[N-1];
  assign out_side  = side_r[N-1];
  assign out_ov    = ov_r[N-1];

endmodule

>>> rtl/cpcr_resp.sv
// ----------------------------------------------------------------------------
// cpcr_resp: collision response datapath
// Seven stages: normal and tangent projections, position shift, friction
// scaling, normal exchange, rounding and saturation, miss pass-through.
// ----------------------------------------------------------------------------
module cpcr_resp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic [16:0]                         gain,
  input  logic                                in_valid,
  input  cpcr_pkg::side_t                     in_side,
  input  logic signed [cpcr_pkg::NORM_W-1:0]  in_nx,
  input  logic signed [cpcr_pkg::NORM_W-1:0]  in_ny,
  input  logic signed [cpcr_pkg::NORM_W-1:0]  in_tx,
  input  logic [16:0]                         in_ov,
  output logic                                out_valid,
  output cpcr_pkg::out_t                      out_data
);

  localparam int NW = cpcr_pkg::NORM_W;

  // ---- stage 1: velocity projections and shift product
  logic                   r1_v_r;
  cpcr_pkg::in_t          r1_pair_r;
  logic                   r1_hit_r;
  logic signed [NW-1:0]   r1_nx_r, r1_ny_r, r1_tx_r;
  logic signed [35:0]     r1_px_r, r1_py_r;
  logic signed [41:0]     r1_pr_r [8];
  logic signed [23:0]     vs [8];
  logic signed [NW-1:0]   ns [8];
  logic signed [NW-1:0]   ovs;

  assign ovs = $signed({1'b0, in_ov});

  always_comb begin
    vs[0] = in_side.pair.first_vel_x;   ns[0] = in_nx;
    vs[1] = in_side.pair.first_vel_y;   ns[1] = in_ny;
    vs[2] = in_side.pair.first_vel_x;   ns[2] = in_tx;
    vs[3] = in_side.pair.first_vel_y;   ns[3] = in_nx;
    vs[4] = in_side.pair.second_vel_x;  ns[4] = in_nx;
    vs[5] = in_side.pair.second_vel_y;  ns[5] = in_ny;
    vs[6] = in_side.pair.second_vel_x;  ns[6] = in_tx;
    vs[7] = in_side.pair.second_vel_y;  ns[7] = in_nx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_pair_r <= in_side.pair;
      r1_hit_r  <= in_side.hit;
      r1_nx_r   <= in_nx;
      r1_ny_r   <= in_ny;
      r1_tx_r   <= in_tx;
      r1_px_r   <= in_nx * ovs;
      r1_py_r   <= in_ny * ovs;
      for (int k = 0; k < 8; k++) r1_pr_r[k] <= vs[k] * ns[k];
    end
  end

  // ---- stage 2: projection sums, rounded position shift
  logic                   r2_v_r;
  cpcr_pkg::in_t          r2_pair_r;
  logic                   r2_hit_r;
  logic signed [NW-1:0]   r2_nx_r, r2_ny_r, r2_tx_r;
  logic signed [17:0]     r2_sx_r, r2_sy_r;
  logic signed [42:0]     r2_s_r [4];   // n1, t1, n2, t2
  logic signed [63:0]     rnd_sx, rnd_sy;

  assign rnd_sx = cpcr_pkg::rnd_shift(64'(r1_px_r), cpcr_pkg::NORM_BITS + 1);
  assign rnd_sy = cpcr_pkg::rnd_shift(64'(r1_py_r), cpcr_pkg::NORM_BITS + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_pair_r <= r1_pair_r;
      r2_hit_r  <= r1_hit_r;
      r2_nx_r   <= r1_nx_r;
      r2_ny_r   <= r1_ny_r;
      r2_tx_r   <= r1_tx_r;
      r2_sx_r   <= rnd_sx[17:0];
      r2_sy_r   <= rnd_sy[17:0];
      for (int j = 0; j < 4; j++) begin
        r2_s_r[j] <= 43'(r1_pr_r[2*j]) + 43'(r1_pr_r[2*j+1]);
      end
    end
  end

  // ---- stage 3: friction partial products, separated positions
  logic                   r3_v_r;
  cpcr_pkg::in_t          r3_pair_r;
  logic                   r3_hit_r;
  logic signed [NW-1:0]   r3_nx_r, r3_ny_r, r3_tx_r;
  logic signed [42:0]     r3_n1_r, r3_n2_r;
  logic signed [40:0]     r3_glo_r [2];
  logic signed [38:0]     r3_ghi_r [2];
  logic signed [23:0]     r3_pos_r [4];
  logic signed [NW-1:0]   gs;
  logic signed [42:0]     tan_s [2];
  logic signed [23:0]     pos_in [4];
  logic signed [17:0]     pos_sh [4];
  logic signed [24:0]     pos_sum [4];

  assign gs = $signed({1'b0, gain});

  always_comb begin
    tan_s[0]  = r2_s_r[1];
    tan_s[1]  = r2_s_r[3];
    pos_in[0] = r2_pair_r.first_pos_x;   pos_sh[0] = r2_sx_r;
    pos_in[1] = r2_pair_r.first_pos_y;   pos_sh[1] = r2_sy_r;
    pos_in[2] = r2_pair_r.second_pos_x;  pos_sh[2] = -r2_sx_r;
    pos_in[3] = r2_pair_r.second_pos_y;  pos_sh[3] = -r2_sy_r;
    for (int k = 0; k < 4; k++) begin
      pos_sum[k] = 25'(pos_in[k]) + 25'(pos_sh[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r3_pair_r <= r2_pair_r;
      r3_hit_r  <= r2_hit_r;
      r3_nx_r   <= r2_nx_r;
      r3_ny_r   <= r2_ny_r;
      r3_tx_r   <= r2_tx_r;
      r3_n1_r   <= r2_s_r[0];
      r3_n2_r   <= r2_s_r[2];
      for (int m = 0; m < 2; m++) begin
        r3_glo_r[m] <= $signed({1'b0, tan_s[m][21:0]}) * gs;
        r3_ghi_r[m] <= $signed(tan_s[m][42:22]) * gs;
      end
      for (int k = 0; k < 4; k++) r3_pos_r[k] <= cpcr_pkg::sat24(64'(pos_sum[k]));
    end
  end

  // ---- stage 4: scaled tangents
  logic                   r4_v_r;
  cpcr_pkg::in_t          r4_pair_r;
  logic                   r4_hit_r;
  logic signed [NW-1:0]   r4_nx_r, r4_ny_r, r4_tx_r;
  logic signed [42:0]     r4_n1_r, r4_n2_r;
  logic signed [42:0]     r4_tf_r [2];
  logic signed [23:0]     r4_pos_r [4];
  logic signed [63:0]     tf_rnd [2];

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      tf_rnd[m] = cpcr_pkg::rnd_shift((64'(r3_ghi_r[m]) <<< 22) + 64'(r3_glo_r[m]),
                                      cpcr_pkg::NORM_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4_pair_r <= r3_pair_r;
      r4_hit_r  <= r3_hit_r;
      r4_nx_r   <= r3_nx_r;
      r4_ny_r   <= r3_ny_r;
      r4_tx_r   <= r3_tx_r;
      r4_n1_r   <= r3_n1_r;
      r4_n2_r   <= r3_n2_r;
      for (int m = 0; m < 2; m++) r4_tf_r[m] <= tf_rnd[m][42:0];
      for (int k = 0; k < 4; k++) r4_pos_r[k] <= r3_pos_r[k];
    end
  end

  // ---- stage 5: rebuild partial products (normal swapped between circles)
  logic                   r5_v_r;
  cpcr_pkg::in_t          r5_pair_r;
  logic                   r5_hit_r;
  logic signed [40:0]     r5_lo_r [8];
  logic signed [38:0]     r5_hi_r [8];
  logic signed [23:0]     r5_pos_r [4];
  logic signed [42:0]     xs [8];
  logic signed [NW-1:0]   ys [8];

  always_comb begin
    xs[0] = r4_n2_r;     ys[0] = r4_nx_r;
    xs[1] = r4_tf_r[0];  ys[1] = r4_tx_r;
    xs[2] = r4_n2_r;     ys[2] = r4_ny_r;
    xs[3] = r4_tf_r[0];  ys[3] = r4_nx_r;
    xs[4] = r4_n1_r;     ys[4] = r4_nx_r;
    xs[5] = r4_tf_r[1];  ys[5] = r4_tx_r;
    xs[6] = r4_n1_r;     ys[6] = r4_ny_r;
    xs[7] = r4_tf_r[1];  ys[7] = r4_nx_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_pair_r <= r4_pair_r;
      r5_hit_r  <= r4_hit_r;
      for (int k = 0; k < 8; k++) begin
        r5_lo_r[k] <= $signed({1'b0, xs[k][21:0]}) * ys[k];
        r5_hi_r[k] <= $signed(xs[k][42:22]) * ys[k];
      end
      for (int k = 0; k < 4; k++) r5_pos_r[k] <= r4_pos_r[k];
    end
  end

  // ---- stage 6: combine partial products
  logic                   r6_v_r;
  cpcr_pkg::in_t          r6_pair_r;
  logic                   r6_hit_r;
  logic signed [60:0]     r6_full_r [8];
  logic signed [23:0]     r6_pos_r [4];
  logic signed [63:0]     full_sum [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      full_sum[k] = (64'(r5_hi_r[k]) <<< 22) + 64'(r5_lo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r6_pair_r <= r5_pair_r;
      r6_hit_r  <= r5_hit_r;
      for (int k = 0; k < 8; k++) r6_full_r[k] <= full_sum[k][60:0];
      for (int k = 0; k < 4; k++) r6_pos_r[k] <= r5_pos_r[k];
    end
  end

  // ---- stage 7: velocity sums, rounding, saturation, miss pass-through
  logic                   r7_v_r;
  cpcr_pkg::out_t         r7_data_r;
  cpcr_pkg::out_t         res_nxt;
  logic signed [63:0]     vel_rnd [4];
  logic signed [23:0]     vel_sat [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      vel_rnd[j] = cpcr_pkg::rnd_shift(64'(r6_full_r[2*j]) + 64'(r6_full_r[2*j+1]),
                                       2 * cpcr_pkg::NORM_BITS);
      vel_sat[j] = cpcr_pkg::sat24(vel_rnd[j]);
    end
    if (r6_hit_r) begin
      res_nxt.new_first_pos_x  = r6_pos_r[0];
      res_nxt.new_first_pos_y  = r6_pos_r[1];
      res_nxt.new_first_vel_x  = vel_sat[0];
      res_nxt.new_first_vel_y  = vel_sat[1];
      res_nxt.new_second_pos_x = r6_pos_r[2];
      res_nxt.new_second_pos_y = r6_pos_r[3];
      res_nxt.new_second_vel_x = vel_sat[2];
      res_nxt.new_second_vel_y = vel_sat[3];
      res_nxt.collided         = 1'b1;
    end else begin
      res_nxt.new_first_pos_x  = r6_pair_r.first_pos_x;
      res_nxt.new_first_pos_y  = r6_pair_r.first_pos_y;
      res_nxt.new_first_vel_x  = r6_pair_r.first_vel_x;
      res_nxt.new_first_vel_y  = r6_pair_r.first_vel_y;
      res_nxt.new_second_pos_x = r6_pair_r.second_pos_x;
      res_nxt.new_second_pos_y = r6_pair_r.second_pos_y;
      res_nxt.new_second_vel_x = r6_pair_r.second_vel_x;
      res_nxt.new_second_vel_y = r6_pair_r.second_vel_y;
      res_nxt.collided         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r7_data_r <= res_nxt;
    end
  end

  // Valid bits for all seven stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      r3_v_r <= 1'b0;
      r4_v_r <= 1'b0;
      r5_v_r <= 1'b0;
      r6_v_r <= 1'b0;
      r7_v_r <= 1'b0;
    end else if (en) begin
      r1_v_r <= in_valid;
      r2_v_r <= r1_v_r;
      r3_v_r <= r2_v_r;
      r4_v_r <= r3_v_r;
      r5_v_r <= r4_v_r;
      r6_v_r <= r5_v_r;
      r7_v_r <= r6_v_r;
    end
  end

  assign out_valid = r7_v_r;
  assign out_data  = r7_data_r;

endmodule

>>> rtl/circle_pair_collision_response.sv
// ----------------------------------------------------------------------------
// circle_pair_collision_response: 2D circle pair contact resolver
// Overlap test, separation and velocity response for one circle pair.
// ----------------------------------------------------------------------------
// Takes one circle pair per clock while in_stall is low. The pipeline is made
// of the 17-stage square root and the 17-stage normal divider, each producing
// one result bit per stage, plus four front stages (input, difference,
// squares, compare) and seven response stages. A two-entry output buffer lets
// a stalled result wait while the pipeline keeps running; in_stall rises only
// once both entries are full. friction_gain is written through
// cfg_valid/cfg_data (always ready) and clamps at 1.0; write it only while no
// pair is in flight.
// ----------------------------------------------------------------------------
module circle_pair_collision_response (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cpcr_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cpcr_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [16:0]     cfg_data
);

  logic           en;
  logic [16:0]    gain_r;

  // Friction gain register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= cpcr_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= (cfg_data > cpcr_pkg::GAIN_ONE) ? cpcr_pkg::GAIN_ONE : cfg_data;
    end
  end

  // ---- front stage 0: input register
  logic            f0_v_r;
  cpcr_pkg::in_t   f0_pair_r;

  // ---- front stage 1: centre difference, radius sum
  logic               f1_v_r;
  cpcr_pkg::in_t      f1_pair_r;
  logic signed [24:0] f1_dx_r, f1_dy_r;
  logic [16:0]        f1_rs_r;

  // ---- front stage 2: squares
  logic               f2_v_r;
  cpcr_pkg::in_t      f2_pair_r;
  logic signed [24:0] f2_dx_r, f2_dy_r;
  logic [16:0]        f2_rs_r;
  logic signed [49:0] f2_dx2_r, f2_dy2_r;
  logic [33:0]        f2_rs2_r;

  // ---- front stage 3: overlap test
  logic                         f3_v_r;
  logic [cpcr_pkg::RAD_W-1:0]   f3_rad_r;
  cpcr_pkg::side_t              f3_side_r;

  logic [49:0]        d2;
  logic [24:0]        dx_abs, dy_abs;
  cpcr_pkg::side_t    side_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      f0_pair_r <= in_data;

      f1_pair_r <= f0_pair_r;
      f1_dx_r   <= $signed({f0_pair_r.first_pos_x[23], f0_pair_r.first_pos_x})
                 - $signed({f0_pair_r.second_pos_x[23], f0_pair_r.second_pos_x});
      f1_dy_r   <= $signed({f0_pair_r.first_pos_y[23], f0_pair_r.first_pos_y})
                 - $signed({f0_pair_r.second_pos_y[23], f0_pair_r.second_pos_y});
      f1_rs_r   <= {1'b0, f0_pair_r.first_radius} + {1'b0, f0_pair_r.second_radius};

      f2_pair_r <= f1_pair_r;
      f2_dx_r   <= f1_dx_r;
      f2_dy_r   <= f1_dy_r;
      f2_rs_r   <= f1_rs_r;
      f2_dx2_r  <= f1_dx_r * f1_dx_r;
      f2_dy2_r  <= f1_dy_r * f1_dy_r;
      f2_rs2_r  <= f1_rs_r * f1_rs_r;

      f3_rad_r  <= d2[cpcr_pkg::RAD_W-1:0];
      f3_side_r <= side_nxt;
    end
  end

  // Squared distance against squared radius sum; on a hit |d| <= h < 2^17
  assign d2     = {1'b0, f2_dx2_r[48:0]} + {1'b0, f2_dy2_r[48:0]};
  assign dx_abs = f2_dx_r[24] ? -f2_dx_r : f2_dx_r;
  assign dy_abs = f2_dy_r[24] ? -f2_dy_r : f2_dy_r;

  always_comb begin
    side_nxt.pair   = f2_pair_r;
    side_nxt.hit    = (d2 <= {16'b0, f2_rs2_r});
    side_nxt.rs     = f2_rs_r;
    side_nxt.dx_mag = dx_abs[16:0];
    side_nxt.dx_neg = f2_dx_r[24];
    side_nxt.dy_mag = dy_abs[16:0];
    side_nxt.dy_neg = f2_dy_r[24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f0_v_r <= in_valid;
      f1_v_r <= f0_v_r;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  // ---- square root of the squared distance
  logic                          sq_valid;
  logic [cpcr_pkg::ROOT_W-1:0]   sq_root;
  cpcr_pkg::side_t               sq_side;

  cpcr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f3_v_r),
    .in_rad    (f3_rad_r),
    .in_side   (f3_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---- unit normal
  logic                                dv_valid;
  cpcr_pkg::side_t                     dv_side;
  logic signed [cpcr_pkg::NORM_W-1:0]  dv_nx, dv_ny, dv_tx;
  logic [16:0]                         dv_ov;

  cpcr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_nx    (dv_nx),
    .out_ny    (dv_ny),
    .out_tx    (dv_tx),
    .out_ov    (dv_ov)
  );

  // ---- response datapath
  logic             rp_valid;
  cpcr_pkg::out_t   rp_data;

  cpcr_resp u_resp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .gain      (gain_r),
    .in_valid  (dv_valid),
    .in_side   (dv_side),
    .in_nx     (dv_nx),
    .in_ny     (dv_ny),
    .in_tx     (dv_tx),
    .in_ov     (dv_ov),
    .out_valid (rp_valid),
    .out_data  (rp_data)
  );

  // ---- two-entry output buffer; pipeline runs while the skid entry is free
  logic             o_v_r, s_v_r;
  cpcr_pkg::out_t   o_data_r, s_data_r;
  logic             pop, push;

  assign en   = !s_v_r;
  assign pop  = o_v_r && !out_stall;
  assign push = en && rp_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (s_v_r) begin
      if (pop) begin
        o_data_r <= s_data_r;
        s_v_r    <= 1'b0;
      end
    end else if (push) begin
      if (!o_v_r || pop) begin
        o_data_r <= rp_data;
        o_v_r    <= 1'b1;
      end else begin
        s_data_r <= rp_data;
        s_v_r    <= 1'b1;
      end
    end else if (pop) begin
      o_v_r <= 1'b0;
    end
  end

  assign in_stall  = s_v_r;
  assign out_valid = o_v_r;
  assign out_data  = o_data_r;

endmodule
